/* rtl/pps_pkg.sv */
// shared types, codes and helpers for the panel power sequencer
package pps_pkg;

  // width of the sleep / await counter
  localparam int unsigned DELAY_BITS = 16;
  // width of the delay field carried by a command
  localparam int unsigned DELAY_IN_W = 16;
  // wide enough to compare an incoming delay against the counter limit
  localparam int unsigned DELAY_WIDE = (DELAY_BITS > DELAY_IN_W) ? DELAY_BITS : DELAY_IN_W;
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  typedef logic [DELAY_BITS-1:0] delay_t;

  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_EXIT     = 3'd0,
    CMD_SET_PIN  = 3'd1,
    CMD_POWER_ON = 3'd2,
    CMD_AWAIT    = 3'd3,
    CMD_UNKNOWN  = 3'd4
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SLEEP = 2'd1,
    PH_AWAIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e phase;
    delay_t ticks_left;
    logic   awaited_level;
  } seq_state_t;

  typedef struct packed {
    op_e                   op;
    cmd_kind_e             cmd_kind;
    logic [7:0]            pin_index;
    logic                  pin_value;
    logic [DELAY_IN_W-1:0] delay_ms;
    logic                  pin_level;
  } in_item_t;

  typedef struct packed {
    logic drive_strobe;
    logic drive_level;
    logic make_input;
    logic power_pulse;
    logic busy_res;
    logic finished;
    logic timed_out;
    logic rejected;
  } out_item_t;

  // saturate an incoming delay to what the counter holds
  function automatic delay_t clamp_delay(logic [DELAY_IN_W-1:0] d);
    logic [DELAY_WIDE-1:0] wide;
    wide = DELAY_WIDE'(d);
    if (wide > DELAY_WIDE'(DELAY_MAX)) begin
      return DELAY_MAX;
    end
    return DELAY_BITS'(wide);
  endfunction

endpackage

/* rtl/pps_if.sv */
// handshake channel interfaces for command input and result output
interface pps_in_if;
  import pps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [2:0]            cmd_kind;
  logic [7:0]            pin_index;
  logic                  pin_value;
  logic [DELAY_IN_W-1:0] delay_ms;
  logic                  pin_level;

  modport source (output valid, op, cmd_kind, pin_index, pin_value, delay_ms, pin_level,
                  input ready);
  modport sink   (input valid, op, cmd_kind, pin_index, pin_value, delay_ms, pin_level,
                  output ready);
endinterface

interface pps_out_if;
  logic valid;
  logic ready;
  logic drive_strobe;
  logic drive_level;
  logic make_input;
  logic power_pulse;
  logic busy_res;
  logic finished;
  logic timed_out;
  logic rejected;

  modport source (output valid, drive_strobe, drive_level, make_input, power_pulse,
                  busy_res, finished, timed_out, rejected,
                  input ready);
  modport sink   (input valid, drive_strobe, drive_level, make_input, power_pulse,
                  busy_res, finished, timed_out, rejected,
                  output ready);
endinterface

/* rtl/pps_step.sv */
// sequencer next-state and result logic for one registered item
module pps_step
  import pps_pkg::*;
(
  input  in_item_t   item_i,
  input  seq_state_t state_i,
  output seq_state_t state_o,
  output out_item_t  result_o
);

  delay_t dly;
  logic   pin0;

  assign dly  = clamp_delay(item_i.delay_ms);
  assign pin0 = (item_i.pin_index == 8'd0);

  // next state
  always_comb begin
    state_o = state_i;
    case (item_i.op)
      OP_START: begin
        state_o.phase      = PH_IDLE;
        state_o.ticks_left = '0;
      end
      OP_TICK: begin
        case (state_i.phase)
          PH_SLEEP: begin
            if (state_i.ticks_left > 1) begin
              state_o.ticks_left = state_i.ticks_left - 1'b1;
            end else begin
              state_o.ticks_left = '0;
              state_o.phase      = PH_IDLE;
            end
          end
          PH_AWAIT: begin
            if (state_i.ticks_left == '0) begin
              state_o.phase = PH_IDLE;
            end else if (item_i.pin_level == state_i.awaited_level) begin
              state_o.phase      = PH_IDLE;
              state_o.ticks_left = '0;
            end else begin
              state_o.ticks_left = state_i.ticks_left - 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_CMD: begin
        if (state_i.phase == PH_IDLE) begin
          case (item_i.cmd_kind)
            CMD_EXIT: begin
              state_o.phase      = PH_DONE;
              state_o.ticks_left = '0;
            end
            CMD_AWAIT: begin
              if (pin0) begin
                state_o.awaited_level = item_i.pin_value;
                if (dly != '0 && item_i.pin_level != item_i.pin_value) begin
                  state_o.ticks_left = dly - 1'b1;
                  state_o.phase      = PH_AWAIT;
                end
              end
            end
            default: begin
              // set pin, power-on and unknown kinds all sleep their delay
              if (dly != '0) begin
                state_o.ticks_left = dly;
                state_o.phase      = PH_SLEEP;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    result_o = '0;
    case (item_i.op)
      OP_TICK: begin
        result_o.timed_out = (state_i.phase == PH_AWAIT) && (state_i.ticks_left == '0);
      end
      OP_CMD: begin
        if (state_i.phase != PH_IDLE) begin
          result_o.rejected = 1'b1;
        end else begin
          case (item_i.cmd_kind)
            CMD_SET_PIN: begin
              result_o.drive_strobe = pin0;
              result_o.drive_level  = pin0 & item_i.pin_value;
            end
            CMD_POWER_ON: result_o.power_pulse = 1'b1;
            CMD_AWAIT: begin
              result_o.make_input = pin0;
              result_o.timed_out  = pin0 && (dly == '0);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    result_o.busy_res = (state_o.phase == PH_SLEEP) || (state_o.phase == PH_AWAIT);
    result_o.finished = (state_o.phase == PH_DONE);
  end

endmodule

/* rtl/panel_power_sequencer.sv */
// top level of the panel power sequencer
// The sequencer runs a display panel's power command list, one command per
// transaction on the input channel, alongside millisecond tick and start
// transactions. Every input transaction gives exactly one result transaction.
// A new transaction is taken every clock cycle while the output channel
// takes results. Each result passes two registers: the input register
// loads when its transaction is accepted, and the result register loads
// from it once the result register is free or draining. The whole command
// decode and counter update for one transaction sits between those two
// registers, so the sequencer state is updated as the result is registered
// and the next transaction sees it at once. The input register keeps
// accepting while a finished result waits on a stalled output, until both
// registers are full. Delays are counted in tick transactions; a delay that
// does not fit the counter is saturated.
module panel_power_sequencer
  import pps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pps_in_if.sink    in_i,
  pps_out_if.source out_o
);

  // input register
  logic       in_valid_q;
  in_item_t   in_q;

  // sequencer state
  seq_state_t state_q;
  seq_state_t state_d;

  // result register
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  result;

  logic       advance;

  // move the held item forward when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  pps_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // input stage: valid bit under reset, payload plain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.op        <= op_e'(in_i.op);
      in_q.cmd_kind  <= cmd_kind_e'(in_i.cmd_kind);
      in_q.pin_index <= in_i.pin_index;
      in_q.pin_value <= in_i.pin_value;
      in_q.delay_ms  <= in_i.delay_ms;
      in_q.pin_level <= in_i.pin_level;
    end
  end

  // sequencer state updates only when its transaction's result is captured
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_IDLE;
      state_q.ticks_left    <= '0;
      state_q.awaited_level <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_strobe = out_q.drive_strobe;
  assign out_o.drive_level  = out_q.drive_level;
  assign out_o.make_input   = out_q.make_input;
  assign out_o.power_pulse  = out_q.power_pulse;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.finished     = out_q.finished;
  assign out_o.timed_out    = out_q.timed_out;
  assign out_o.rejected     = out_q.rejected;

endmodule

/* tb/pps_result_checker.sv */
// result checker for the panel power sequencer: predicts every result and compares it
`timescale 1ns / 100ps

module pps_result_checker
  import pps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pps_in_if    cmd_i,
  pps_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  // predicted sequencer state
  phase_e phase_q;
  delay_t ticks_q;
  logic   awaited_q;

  out_item_t expected_results[$];
  int fails = 0;

  assign fail_count_o = fails;

  // next result for one accepted input transaction; advances the predicted state
  function automatic out_item_t sequence_step(logic [1:0] op, logic [2:0] kind,
                                              logic [7:0] pidx, logic pval,
                                              logic [DELAY_IN_W-1:0] delay_ms, logic lvl);
    out_item_t r;
    logic [31:0] dwide;
    delay_t dly;
    r = '0;
    dwide = 32'(delay_ms);
    dly = (dwide > 32'(DELAY_MAX)) ? DELAY_MAX : delay_t'(dwide);
    case (op)
      OP_START: begin
        phase_q = PH_IDLE;
        ticks_q = '0;
      end
      OP_TICK: begin
        if (phase_q == PH_SLEEP) begin
          if (ticks_q != '0) ticks_q = ticks_q - 1'b1;
          if (ticks_q == '0) phase_q = PH_IDLE;
        end else if (phase_q == PH_AWAIT) begin
          if (ticks_q == '0) begin
            r.timed_out = 1'b1;
            phase_q = PH_IDLE;
          end else if (lvl == awaited_q) begin
            phase_q = PH_IDLE;
            ticks_q = '0;
          end else begin
            ticks_q = ticks_q - 1'b1;
          end
        end
      end
      OP_CMD: begin
        if (phase_q != PH_IDLE) begin
          r.rejected = 1'b1;
        end else if (kind == CMD_EXIT) begin
          phase_q = PH_DONE;
          ticks_q = '0;
        end else if (kind == CMD_AWAIT) begin
          if (pidx == 8'd0) begin
            r.make_input = 1'b1;
            awaited_q = pval;
            if (dly == '0) begin
              r.timed_out = 1'b1;
            end else if (lvl != pval) begin
              ticks_q = dly - 1'b1;
              phase_q = PH_AWAIT;
            end
          end
        end else begin
          // set pin, power-on and unknown kinds all sleep their delay
          if (kind == CMD_SET_PIN && pidx == 8'd0) begin
            r.drive_strobe = 1'b1;
            r.drive_level = pval;
          end else if (kind == CMD_POWER_ON) begin
            r.power_pulse = 1'b1;
          end
          if (dly != '0) begin
            ticks_q = dly;
            phase_q = PH_SLEEP;
          end
        end
      end
      default: ;
    endcase
    r.busy_res = (phase_q == PH_SLEEP) || (phase_q == PH_AWAIT);
    r.finished = (phase_q == PH_DONE);
    return r;
  endfunction

  task automatic compare_field(string name, logic exp_bit, logic act_bit);
    if (act_bit !== exp_bit) begin
      $error("%s: expected %0d, got %0d", name, exp_bit, act_bit);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      phase_q = PH_IDLE;
      ticks_q = '0;
      awaited_q = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // the result side first: a result always belongs to an earlier command
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expected result pending");
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("drive_strobe", exp_r.drive_strobe, res_i.drive_strobe);
          compare_field("drive_level", exp_r.drive_level, res_i.drive_level);
          compare_field("make_input", exp_r.make_input, res_i.make_input);
          compare_field("power_pulse", exp_r.power_pulse, res_i.power_pulse);
          compare_field("busy_res", exp_r.busy_res, res_i.busy_res);
          compare_field("finished", exp_r.finished, res_i.finished);
          compare_field("timed_out", exp_r.timed_out, res_i.timed_out);
          compare_field("rejected", exp_r.rejected, res_i.rejected);
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        expected_results.push_back(sequence_step(cmd_i.op, cmd_i.cmd_kind, cmd_i.pin_index,
                                                 cmd_i.pin_value, cmd_i.delay_ms,
                                                 cmd_i.pin_level));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/panel_power_sequencer_test.sv */
// testbench top for the panel power sequencer: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module panel_power_sequencer_test
  import pps_pkg::*;
;

  // random part stops once this many transactions were sent in total
  localparam int ITEM_TARGET = 1275;
  // cycles without any accepted transaction before the run is declared hung
  localparam int HANG_LIMIT = 500;
  // settle time after the last result, a little over the two-stage pipeline
  localparam int TAIL_CYCLES = 6;

  logic clk;
  logic rst_n = 1'b0;

  pps_in_if  in_if ();
  pps_out_if out_if ();

  int fails;
  int pending;
  int items_sent = 0;
  int n_sequences = 0;
  int n_noise = 0;
  int quiet_cycles = 0;
  // when set, neither side inserts wait cycles
  bit no_idle = 1'b0;

  panel_power_sequencer DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pps_result_checker u_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (in_if),
    .res_i        (out_if),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // wait cycles before the next transaction on either side
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // one input transaction: optional gap, then hold valid until accepted
  task automatic send_item(logic [1:0] op, logic [2:0] kind, logic [7:0] idx, logic val,
                           logic [15:0] dly, logic lvl);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.cmd_kind  <= kind;
    in_if.pin_index <= idx;
    in_if.pin_value <= val;
    in_if.delay_ms  <= dly;
    in_if.pin_level <= lvl;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // a tick carries junk in the command fields, which must be ignored
  task automatic send_tick(logic lvl);
    send_item(OP_TICK, 3'($urandom), 8'($urandom), 1'($urandom), 16'($urandom), lvl);
  endtask

  task automatic send_start();
    send_item(OP_START, 3'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
              1'($urandom));
  endtask

  // hold off the sender until every outstanding result came back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // start, a short command list with the ticks it needs, usually an exit
  task automatic run_sequence();
    int n_cmds;
    int n_ticks;
    logic [2:0] kind;
    logic [7:0] idx;
    logic val;
    logic [15:0] dly;
    logic lvl;
    send_start();
    n_cmds = $urandom_range(2, 8);
    repeat (n_cmds) begin
      case ($urandom_range(0, 9))
        0, 1, 2: kind = CMD_SET_PIN;
        3, 4:    kind = CMD_POWER_ON;
        5, 6, 7: kind = CMD_AWAIT;
        default: kind = CMD_UNKNOWN | 3'($urandom_range(0, 3));
      endcase
      idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      val = 1'($urandom);
      dly = ($urandom_range(0, 24) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      if (kind == CMD_AWAIT) begin
        // mostly miss at first so the await really waits
        lvl = ($urandom_range(0, 2) == 0) ? val : ~val;
      end else begin
        lvl = 1'($urandom);
      end
      send_item(OP_CMD, kind, idx, val, dly, lvl);
      if (dly > 16) begin
        // long delay: tick a few times, then abandon it with a start
        repeat ($urandom_range(0, 3)) send_tick(1'($urandom));
        send_start();
      end else begin
        // usually the exact tick count; sometimes one short (next command
        // gets rejected) or one extra (tick while idle)
        n_ticks = int'(dly) - 1 + int'($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0) n_ticks = int'(dly);
        if (n_ticks < 0) n_ticks = 0;
        repeat (n_ticks) begin
          if (kind == CMD_AWAIT) begin
            send_tick(($urandom_range(0, 3) == 0) ? val : ~val);
          end else begin
            send_tick(1'($urandom));
          end
        end
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      send_item(OP_CMD, CMD_EXIT, 8'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
      // commands after an exit are refused until the next start
      if ($urandom_range(0, 2) == 0) begin
        send_item(OP_CMD, 3'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                  1'($urandom));
        send_tick(1'($urandom));
      end
    end
    n_sequences++;
  endtask

  // unstructured transactions over the full field ranges, reserved op included
  task automatic send_noise();
    repeat ($urandom_range(1, 5)) begin
      send_item(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                1'($urandom));
    end
    n_noise++;
  endtask

  // result side: after every accepted result, stall for a drawn number of cycles
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        stall = draw_gap();
        if (stall > 0) out_if.ready <= 1'b0;
      end else if (!out_if.ready) begin
        if (stall > 0) stall--;
        if (stall == 0) out_if.ready <= 1'b1;
      end
    end
  end

  // hang detection: nothing accepted on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_CMD;
    in_if.cmd_kind  <= CMD_EXIT;
    in_if.pin_index <= '0;
    in_if.pin_value <= 1'b0;
    in_if.delay_ms  <= '0;
    in_if.pin_level <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain commands with no delay
    send_item(OP_CMD, CMD_SET_PIN, 8'd0, 1'b1, 16'd0, 1'b0);
    send_item(OP_CMD, CMD_SET_PIN, 8'd0, 1'b0, 16'd0, 1'b1);
    // set pin on a nonzero pin is ignored
    send_item(OP_CMD, CMD_SET_PIN, 8'd255, 1'b1, 16'd0, 1'b0);
    send_item(OP_CMD, CMD_POWER_ON, 8'd0, 1'b0, 16'd0, 1'b0);
    // unknown kinds do nothing
    send_item(OP_CMD, CMD_UNKNOWN, 8'd0, 1'b1, 16'd0, 1'b1);
    send_item(OP_CMD, CMD_UNKNOWN | 3'd3, 8'd0, 1'b1, 16'd0, 1'b1);
    // sleep of two ticks with a command refused in between
    send_item(OP_CMD, CMD_POWER_ON, 8'd0, 1'b0, 16'd2, 1'b0);
    send_item(OP_CMD, CMD_SET_PIN, 8'd0, 1'b1, 16'd0, 1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    // await with zero delay times out at once
    send_item(OP_CMD, CMD_AWAIT, 8'd0, 1'b1, 16'd0, 1'b0);
    // await that matches on the first sample
    send_item(OP_CMD, CMD_AWAIT, 8'd0, 1'b1, 16'd5, 1'b1);
    // await on a nonzero pin does not wait
    send_item(OP_CMD, CMD_AWAIT, 8'd170, 1'b1, 16'd3, 1'b0);
    // await of two samples that runs out
    send_item(OP_CMD, CMD_AWAIT, 8'd0, 1'b1, 16'd2, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    // await on the largest limit, matched on the first tick
    send_item(OP_CMD, CMD_AWAIT, 8'd0, 1'b0, 16'hffff, 1'b1);
    send_tick(1'b0);
    // longest sleep, abandoned by a start
    send_item(OP_CMD, CMD_SET_PIN, 8'd0, 1'b1, 16'hffff, 1'b0);
    send_start();
    // reserved op and a tick while idle
    send_item(OP_RSVD, CMD_SET_PIN, 8'd0, 1'b1, 16'd4, 1'b1);
    send_tick(1'b1);
    // exit ignores its delay, then refuses commands until a start
    send_item(OP_CMD, CMD_EXIT, 8'd0, 1'b0, 16'hffff, 1'b0);
    send_item(OP_CMD, CMD_POWER_ON, 8'd0, 1'b0, 16'd0, 1'b0);
    send_tick(1'b1);
    send_start();
    drain_results();

    // random: mostly well-formed command lists, some noise, idle-free stretches
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        send_noise();
      end else begin
        run_sequence();
      end
      if ((n_sequences + n_noise) % 40 == 0) drain_results();
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d input transactions: %0d command lists and %0d noise bursts",
             items_sent, n_sequences, n_noise);
    $display("%0d mismatches, %0d results still outstanding", fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
